@@ hw/rtl/can_signal_decoder_unit_macros.svh @@
// assertion macros for the can signal decoder unit
`ifndef CAN_SIGNAL_DECODER_UNIT_MACROS_SVH
`define CAN_SIGNAL_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define CSD_ASSERT_IMPLY(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csd implication check failed");

// next-cycle implication, sampled on clk, off while in reset
`define CSD_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csd next-cycle check failed");

`endif

@@ hw/rtl/csd_pkg.sv @@
// shared types, signal table and message table of the can signal decoder
package csd_pkg;

  localparam int ID_W    = 29;
  localparam int LEN_W   = 4;
  localparam int DATA_W  = 64;
  localparam int IDX_W   = 4;
  localparam int VALUE_W = 32;
  localparam int RAW_W   = 16;
  localparam int NUM_SIGS = 9;
  localparam int NUM_MSGS = 3;

  // signal indexes that mark the end of a message or the start of the boolean group
  localparam logic [IDX_W-1:0] SIG_FUEL_LEVEL    = 4'd2;
  localparam logic [IDX_W-1:0] SIG_VEHICLE_SPEED = 4'd4;
  localparam logic [IDX_W-1:0] SIG_LEFT_TURN     = 4'd5;
  localparam logic [IDX_W-1:0] SIG_HANDBRAKE     = 4'd8;

  typedef enum logic [1:0] {
    FAC_ONE,
    FAC_QUARTER,
    FAC_TWO_FIFTHS,
    FAC_CENT
  } fac_t;

  typedef enum logic [0:0] {
    OFS_ZERO,
    OFS_MINUS_40
  } ofs_t;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_INT,
    KIND_BOOL
  } kind_t;

  typedef struct packed {
    logic [4:0] lsb;
    logic [4:0] len;
    logic       sgn;
    fac_t       fac;
    ofs_t       ofs;
    kind_t      kind;
  } sig_def_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [IDX_W-1:0] first;
    logic [2:0]       count;
  } msg_def_t;

  localparam sig_def_t SIG_TAB [NUM_SIGS] = '{
    '{lsb: 5'd0,  len: 5'd16, sgn: 1'b0, fac: FAC_QUARTER,    ofs: OFS_ZERO,     kind: KIND_PLAIN},
    '{lsb: 5'd16, len: 5'd8,  sgn: 1'b0, fac: FAC_ONE,        ofs: OFS_MINUS_40, kind: KIND_PLAIN},
    '{lsb: 5'd24, len: 5'd8,  sgn: 1'b0, fac: FAC_TWO_FIFTHS, ofs: OFS_ZERO,     kind: KIND_PLAIN},
    '{lsb: 5'd0,  len: 5'd8,  sgn: 1'b1, fac: FAC_ONE,        ofs: OFS_ZERO,     kind: KIND_INT},
    '{lsb: 5'd8,  len: 5'd16, sgn: 1'b0, fac: FAC_CENT,       ofs: OFS_ZERO,     kind: KIND_PLAIN},
    '{lsb: 5'd0,  len: 5'd1,  sgn: 1'b0, fac: FAC_ONE,        ofs: OFS_ZERO,     kind: KIND_BOOL},
    '{lsb: 5'd1,  len: 5'd1,  sgn: 1'b0, fac: FAC_ONE,        ofs: OFS_ZERO,     kind: KIND_BOOL},
    '{lsb: 5'd2,  len: 5'd1,  sgn: 1'b0, fac: FAC_ONE,        ofs: OFS_ZERO,     kind: KIND_BOOL},
    '{lsb: 5'd3,  len: 5'd1,  sgn: 1'b0, fac: FAC_ONE,        ofs: OFS_ZERO,     kind: KIND_BOOL}
  };

  localparam msg_def_t MSG_TAB [NUM_MSGS] = '{
    '{id: 29'h100, first: 4'd0, count: 3'd3},
    '{id: 29'h200, first: 4'd3, count: 3'd2},
    '{id: 29'h400, first: 4'd5, count: 3'd4}
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CALC,
    ST_SHAPE
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_frame;
    logic start_msg;
    logic calc;
    logic emit;
  } csd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic msg_hit;
    logic sig_last;
  } csd_sts_t;

endpackage

@@ hw/rtl/csd_if.sv @@
// frame input and signal result channel interfaces
interface csd_in_if;
  logic        valid;
  logic        ready;
  logic [28:0] frame_id;
  logic [3:0]  data_length;
  logic [63:0] frame_data;

  modport source (output valid, frame_id, data_length, frame_data, input ready);
  modport sink (input valid, frame_id, data_length, frame_data, output ready);
endinterface

interface csd_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         signal_index;
  logic signed [31:0] value;
  logic               is_last;

  modport source (output valid, signal_index, value, is_last, input ready);
  modport sink (input valid, signal_index, value, is_last, output ready);
endinterface

@@ hw/rtl/can_signal_decoder_unit.sv @@
// A frame is taken in and its identifier is matched against the three known
// messages in the cycle after; an unknown identifier or a zero data length ends
// the frame there. Each signal of a known message then goes first through the
// multiplier that scales the extracted field and then through truncation, boolean
// threshold and saturation into the result register, a step that waits while the
// result side holds off. The last result of a frame may wait in the result register
// while the next frame is already taken in.
module can_signal_decoder_unit
  import csd_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_BYTES = 8
) (
  input logic         clk,
  input logic         rst_n,
  csd_in_if.sink      in_if,
  csd_out_if.source   out_if
);

`include "can_signal_decoder_unit_macros.svh"

  localparam logic signed [VALUE_W-1:0] ONE_VAL = VALUE_W'(1) << FRAC_BITS;

  csd_cmd_t cmd;
  csd_sts_t sts;

  // sequencing
  csd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // extraction and scaling
  csd_datapath #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_BYTES (DATA_BYTES)
  ) u_datapath (
    .clk              (clk),
    .in_frame_id      (in_if.frame_id),
    .in_data_length   (in_if.data_length),
    .in_frame_data    (in_if.frame_data),
    .cmd              (cmd),
    .sts              (sts),
    .out_signal_index (out_if.signal_index),
    .out_value        (out_if.value),
    .out_is_last      (out_if.is_last)
  );

  // a frame closes only on the last signal of one of the messages
  `CSD_ASSERT_IMPLY(a_last_at_msg_end, out_if.valid && out_if.is_last,
    out_if.signal_index == SIG_FUEL_LEVEL || out_if.signal_index == SIG_VEHICLE_SPEED ||
    out_if.signal_index == SIG_HANDBRAKE)

  // boolean signals are exactly zero or one
  `CSD_ASSERT_IMPLY(a_bool_value, out_if.valid && (out_if.signal_index >= SIG_LEFT_TURN),
    out_if.value == '0 || out_if.value == ONE_VAL)

  // no new frame while the current one still has signals to deliver
  `CSD_ASSERT_IMPLY(a_busy_mid_frame, out_if.valid && !out_if.is_last, !in_if.ready)

  // a taken frame is looked up before the next is taken
  `CSD_ASSERT_NEXT(a_lookup_after_take, in_if.valid && in_if.ready, !in_if.ready)

endmodule

@@ hw/rtl/csd_datapath.sv @@
// frame registers, message lookup, signal extraction, scaling and result register
module csd_datapath
  import csd_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_BYTES = 8
) (
  input  logic                      clk,
  input  logic [ID_W-1:0]           in_frame_id,
  input  logic [LEN_W-1:0]          in_data_length,
  input  logic [DATA_W-1:0]         in_frame_data,
  input  csd_cmd_t                  cmd,
  output csd_sts_t                  sts,
  output logic [IDX_W-1:0]          out_signal_index,
  output logic signed [VALUE_W-1:0] out_value,
  output logic                      out_is_last
);

  localparam int DW  = DATA_BYTES * 8;
  localparam int FW  = FRAC_BITS + 1;
  localparam int SW  = RAW_W + 1;
  localparam int PW  = SW + FW + 1;
  localparam int VW  = (FRAC_BITS + 20 > VALUE_W + 1) ? FRAC_BITS + 20 : VALUE_W + 1;

  // factors rounded to nearest, ties up
  localparam logic [FW-1:0] F_ONE = FW'(64'd1 << FRAC_BITS);
  localparam logic [FW-1:0] F_QUARTER =
    FW'(((64'd1 << (FRAC_BITS + 1)) + 64'd4) / 64'd8);
  localparam logic [FW-1:0] F_TWO_FIFTHS =
    FW'(((64'd2 << (FRAC_BITS + 1)) + 64'd5) / 64'd10);
  localparam logic [FW-1:0] F_CENT =
    FW'(((64'd1 << (FRAC_BITS + 1)) + 64'd100) / 64'd200);

  localparam logic signed [VW-1:0] ONE_Q   = VW'(1) << FRAC_BITS;
  localparam logic signed [VW-1:0] HALF_Q  = VW'(1) << (FRAC_BITS - 1);
  localparam logic signed [VW-1:0] OFS_M40 = -(VW'(40) << FRAC_BITS);

  localparam logic [VALUE_W-1:0] SAT_MAX = {1'b0, {(VALUE_W - 1){1'b1}}};
  localparam logic [VALUE_W-1:0] SAT_MIN = {1'b1, {(VALUE_W - 1){1'b0}}};

  logic [ID_W-1:0]          id_r;
  logic [LEN_W-1:0]         len_r;
  logic [DW-1:0]            data_r;
  logic [DW-1:0]            data_nxt;
  logic [LEN_W-1:0]         nbytes;
  logic [IDX_W-1:0]         sig_idx_r;
  logic [IDX_W-1:0]         last_idx_r;
  logic [IDX_W-1:0]         first_sel;
  logic [IDX_W-1:0]         last_sel;
  logic                     id_match;
  logic signed [VW-1:0]     prod_r;
  logic [IDX_W-1:0]         out_idx_r;
  logic signed [VALUE_W-1:0] out_value_r;
  logic                     out_last_r;

  sig_def_t                 sd;
  logic [DATA_W-1:0]        data_ext;
  logic [DATA_W-1:0]        shifted;
  logic [RAW_W-1:0]         len_mask;
  logic [RAW_W-1:0]         raw;
  logic [4:0]               len_m1;
  logic                     neg;
  logic [SW-1:0]            sub;
  logic signed [SW-1:0]     sraw;
  logic [FW-1:0]            fac;
  logic signed [PW-1:0]     prod;
  logic signed [VW-1:0]     ofs;
  logic signed [VW-1:0]     shaped;
  logic signed [VW-1:0]     trunc;
  logic [VW-VALUE_W:0]      top_bits;
  logic signed [VALUE_W-1:0] sat;

  // clamp the length and clear bytes beyond it
  always_comb begin
    nbytes = (in_data_length > LEN_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES) : in_data_length;
    for (int k = 0; k < DATA_BYTES; k++) begin
      data_nxt[k*8 +: 8] = (LEN_W'(k) < nbytes) ? in_frame_data[k*8 +: 8] : 8'h00;
    end
  end

  // message lookup over the three known identifiers
  always_comb begin
    id_match  = 1'b0;
    first_sel = '0;
    last_sel  = '0;
    for (int m = 0; m < NUM_MSGS; m++) begin
      if (id_r == MSG_TAB[m].id) begin
        id_match  = 1'b1;
        first_sel = MSG_TAB[m].first;
        last_sel  = MSG_TAB[m].first + IDX_W'(MSG_TAB[m].count) - IDX_W'(1);
      end
    end
  end

  assign sts.msg_hit  = id_match && (len_r != '0);
  assign sts.sig_last = (sig_idx_r == last_idx_r);

  // field extraction and sign extension for the current signal
  always_comb begin
    sd       = SIG_TAB[sig_idx_r];
    data_ext = DATA_W'(data_r);
    shifted  = data_ext >> sd.lsb;
    len_mask = RAW_W'((SW'(1) << sd.len) - SW'(1));
    raw      = shifted[RAW_W-1:0] & len_mask;
    len_m1   = sd.len - 5'd1;
    neg      = sd.sgn & raw[len_m1[3:0]];
    sub      = neg ? (SW'(1) << sd.len) : '0;
    sraw     = signed'({1'b0, raw} - sub);
    case (sd.fac)
      FAC_ONE:        fac = F_ONE;
      FAC_QUARTER:    fac = F_QUARTER;
      FAC_TWO_FIFTHS: fac = F_TWO_FIFTHS;
      FAC_CENT:       fac = F_CENT;
      default:        fac = F_ONE;
    endcase
    case (sd.ofs)
      OFS_ZERO:     ofs = '0;
      OFS_MINUS_40: ofs = OFS_M40;
      default:      ofs = '0;
    endcase
    prod = sraw * signed'({1'b0, fac});
  end

  // kind shaping and saturation of the scaled value
  always_comb begin
    trunc = {prod_r[VW-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
    if (prod_r[VW-1] && (|prod_r[FRAC_BITS-1:0])) begin
      trunc = trunc + ONE_Q;
    end
    case (sd.kind)
      KIND_PLAIN: shaped = prod_r;
      KIND_INT:   shaped = trunc;
      KIND_BOOL:  shaped = (prod_r > HALF_Q) ? ONE_Q : '0;
      default:    shaped = prod_r;
    endcase
    top_bits = shaped[VW-1:VALUE_W-1];
    if ((&top_bits) || !(|top_bits)) begin
      sat = shaped[VALUE_W-1:0];
    end else if (shaped[VW-1]) begin
      sat = SAT_MIN;
    end else begin
      sat = SAT_MAX;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      id_r   <= in_frame_id;
      len_r  <= in_data_length;
      data_r <= data_nxt;
    end
    if (cmd.start_msg) begin
      sig_idx_r  <= first_sel;
      last_idx_r <= last_sel;
    end
    if (cmd.calc) begin
      prod_r <= VW'(prod) + ofs;
    end
    if (cmd.emit) begin
      out_idx_r   <= sig_idx_r;
      out_value_r <= sat;
      out_last_r  <= (sig_idx_r == last_idx_r);
      sig_idx_r   <= sig_idx_r + IDX_W'(1);
    end
  end

  assign out_signal_index = out_idx_r;
  assign out_value        = out_value_r;
  assign out_is_last      = out_last_r;

endmodule

@@ hw/rtl/csd_ctrl.sv @@
// controller state machine: frame intake, per-signal sequencing, result handshake
module csd_ctrl
  import csd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output csd_cmd_t cmd,
  input  csd_sts_t sts
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // state and result-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_frame = 1'b1;
          state_nxt      = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (sts.msg_hit) begin
          cmd.start_msg = 1'b1;
          state_nxt     = ST_CALC;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_SHAPE;
      end
      ST_SHAPE: begin
        // load the result register once the previous word has left
        if (!out_valid_r || out_ready) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = sts.sig_last ? ST_IDLE : ST_CALC;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

@@ tb/sv/can_signal_decoder_unit_tb.sv @@
// self-checking testbench for the can signal decoder unit: frames in, scaled signal words out
module can_signal_decoder_unit_tb;
  import csd_pkg::*;

  localparam int FRAC           = 16;
  localparam int FRAME_BYTES    = 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_FRAMES   = 28;

  // identifiers of the three known messages
  localparam logic [28:0] MSG_ENGINE_ID = 29'h100;
  localparam logic [28:0] MSG_DRIVE_ID  = 29'h200;
  localparam logic [28:0] MSG_BODY_ID   = 29'h400;

  // one signal of the built-in table
  typedef struct {
    int    lsb;
    int    len;
    bit    sgn;
    int    num;
    int    den;
    int    ofs;
    kind_t kind;
  } sig_spec_t;

  // one decoded signal word
  typedef struct {
    logic [3:0]         idx;
    logic signed [31:0] value;
    logic               last;
  } sig_word_t;

  // expected signal words per accepted frame, checked in order
  class signal_ledger;
    sig_word_t pending_signals[$];
    int mismatches;
    int signals_checked;
    int frames_noted;

    function new();
      mismatches = 0;
      signals_checked = 0;
      frames_noted = 0;
    endfunction

    function sig_spec_t spec_of(int idx);
      sig_spec_t s;
      case (idx)
        0: s = '{lsb: 0,  len: 16, sgn: 0, num: 1, den: 4,   ofs: 0,   kind: KIND_PLAIN};
        1: s = '{lsb: 16, len: 8,  sgn: 0, num: 1, den: 1,   ofs: -40, kind: KIND_PLAIN};
        2: s = '{lsb: 24, len: 8,  sgn: 0, num: 2, den: 5,   ofs: 0,   kind: KIND_PLAIN};
        3: s = '{lsb: 0,  len: 8,  sgn: 1, num: 1, den: 1,   ofs: 0,   kind: KIND_INT};
        4: s = '{lsb: 8,  len: 16, sgn: 0, num: 1, den: 100, ofs: 0,   kind: KIND_PLAIN};
        default: s = '{lsb: idx - 5, len: 1, sgn: 0, num: 1, den: 1, ofs: 0, kind: KIND_BOOL};
      endcase
      return s;
    endfunction

    // extract, scale to fixed point, shape by kind, saturate
    function logic signed [31:0] scale_signal(logic [63:0] data, sig_spec_t s);
      logic [63:0] mask;
      logic [63:0] raw;
      logic [63:0] fac_num;
      longint      sraw;
      longint      factor;
      longint      one;
      longint      v;
      one = longint'(1) << FRAC;
      mask = (64'd1 << s.len) - 64'd1;
      raw = (data >> s.lsb) & mask;
      if (s.sgn && raw[s.len-1]) sraw = -longint'((~raw & mask) + 64'd1);
      else sraw = longint'(raw);
      // factor rounded to nearest, ties up
      fac_num = (64'(s.num) << (FRAC + 1)) + 64'(s.den);
      factor = longint'(fac_num / (64'(s.den) * 64'd2));
      v = sraw * factor + longint'(s.ofs) * one;
      case (s.kind)
        KIND_INT:  v = (v / one) * one;
        KIND_BOOL: v = (v > one / 2) ? one : 64'sd0;
        default: ;
      endcase
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[31:0];
    endfunction

    function void note_frame(logic [28:0] id, logic [3:0] len, logic [63:0] data);
      int          first;
      int          count;
      int          nbytes;
      int          i;
      logic [63:0] seen;
      sig_word_t   w;
      frames_noted++;
      first = 0;
      count = 0;
      case (id)
        MSG_ENGINE_ID: begin first = 0; count = 3; end
        MSG_DRIVE_ID:  begin first = 3; count = 2; end
        MSG_BODY_ID:   begin first = 5; count = 4; end
        default: count = 0;
      endcase
      nbytes = (int'(len) > FRAME_BYTES) ? FRAME_BYTES : int'(len);
      if (count == 0 || nbytes == 0) return;
      // bytes past the data length read as zero
      seen = (nbytes < 8) ? (data & ((64'd1 << (8 * nbytes)) - 64'd1)) : data;
      for (i = 0; i < count; i++) begin
        w.idx = 4'(first + i);
        w.value = scale_signal(seen, spec_of(first + i));
        w.last = (i == count - 1);
        pending_signals.push_back(w);
      end
    endfunction

    function void check_signal(logic [3:0] idx, logic signed [31:0] value, logic last);
      sig_word_t w;
      if (pending_signals.size() == 0) begin
        mismatches++;
        $display("%0t: signal word with none pending: index %0d value %0d last %0b",
                 $time, idx, value, last);
        return;
      end
      w = pending_signals.pop_front();
      signals_checked++;
      if (idx !== w.idx) begin
        mismatches++;
        $display("%0t: signal_index expected %0d actual %0d", $time, w.idx, idx);
      end
      if (value !== w.value) begin
        mismatches++;
        $display("%0t: value (index %0d) expected %0d actual %0d", $time, w.idx, w.value,
                 value);
      end
      if (last !== w.last) begin
        mismatches++;
        $display("%0t: is_last (index %0d) expected %0b actual %0b", $time, w.idx, w.last,
                 last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct;
  int   stall_pct;
  bit   hold_request;
  int   frames_sent;

  signal_ledger ledger = new();

  csd_in_if  in_if();
  csd_out_if out_if();

  can_signal_decoder_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // monitors on both channels and the watchdog
  initial begin : channel_watch
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      quiet++;
      if (rst_n && in_if.valid && in_if.ready) begin
        ledger.note_frame(in_if.frame_id, in_if.data_length, in_if.frame_data);
        quiet = 0;
      end
      if (rst_n && out_if.valid && out_if.ready) begin
        ledger.check_signal(out_if.signal_index, out_if.value, out_if.is_last);
        quiet = 0;
      end
    end
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // offer one frame and wait for it to be taken
  task send_frame(logic [28:0] id, logic [3:0] len, logic [63:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.frame_id    <= id;
    in_if.data_length <= len;
    in_if.frame_data  <= data;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    frames_sent++;
  endtask

  // random frame, mostly known messages; decodable tells if it yields words
  task send_random_frame(output bit decodable);
    logic [28:0] id;
    logic [3:0]  len;
    logic [63:0] data;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 28) id = MSG_ENGINE_ID;
    else if (pick < 56) id = MSG_DRIVE_ID;
    else if (pick < 84) id = MSG_BODY_ID;
    else id = 29'($urandom);
    pick = $urandom_range(99);
    if (pick < 65) len = 4'd8;
    else if (pick < 88) len = 4'($urandom_range(1, 7));
    else len = 4'($urandom_range(15));
    pick = $urandom_range(99);
    if (pick < 8) data = '1;
    else if (pick < 12) data = '0;
    else data = {$urandom, $urandom};
    decodable = (id == MSG_ENGINE_ID || id == MSG_DRIVE_ID || id == MSG_BODY_ID) &&
                (len != 4'd0);
    send_frame(id, len, data);
  endtask

  // keep sending until enough decodable frames went in
  task run_phase(int idle_pct, int stall, int n);
    int useful;
    bit decodable;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    useful = 0;
    while (useful < n) begin
      send_random_frame(decodable);
      if (decodable) useful++;
    end
  endtask

  // stimulus
  initial begin : stimulus
    rst_n             <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.frame_id    <= '0;
    in_if.data_length <= '0;
    in_if.frame_data  <= '0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b0;
    frames_sent = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, signed gear, short, zero and overlong lengths, booleans, unknown identifiers
    send_frame(MSG_ENGINE_ID, 4'd8, 64'h0);
    send_frame(MSG_ENGINE_ID, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(MSG_ENGINE_ID, 4'd2, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(MSG_ENGINE_ID, 4'd3, 64'h1234_5678_9ABC_DEF0);
    send_frame(MSG_ENGINE_ID, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(MSG_ENGINE_ID, 4'd4, 64'h0000_0000_8027_1F40);
    send_frame(MSG_DRIVE_ID, 4'd8, 64'h0000_0000_0000_0080);
    send_frame(MSG_DRIVE_ID, 4'd8, 64'h0000_0000_0000_007F);
    send_frame(MSG_DRIVE_ID, 4'd8, 64'h0000_0000_00FF_FFFF);
    send_frame(MSG_DRIVE_ID, 4'd1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(MSG_DRIVE_ID, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(MSG_DRIVE_ID, 4'd2, 64'hAAAA_AAAA_AAAA_AA01);
    send_frame(MSG_BODY_ID, 4'd1, 64'h0000_0000_0000_000F);
    send_frame(MSG_BODY_ID, 4'd1, 64'h0000_0000_0000_0005);
    send_frame(MSG_BODY_ID, 4'd1, 64'h0000_0000_0000_000A);
    send_frame(MSG_BODY_ID, 4'd8, 64'hFFFF_FFFF_FFFF_FFF0);
    send_frame(MSG_BODY_ID, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(29'h000_0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(29'h1FFF_FFFF, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(29'h101, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(29'h1000_0400, 4'd8, 64'h0123_4567_89AB_CDEF);
    send_frame(MSG_BODY_ID, 4'd0, 64'h0);

    // random phases with different idling mixes
    run_phase(0, 0, PHASE_FRAMES);
    run_phase(47, 0, PHASE_FRAMES);
    run_phase(0, 47, PHASE_FRAMES);
    run_phase(12, 12, PHASE_FRAMES);

    // long result hold-off while frames keep coming
    hold_request = 1'b1;
    run_phase(0, 0, 12);
    in_if.valid <= 1'b0;

    // drain
    while (ledger.pending_signals.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d frames taken in, %0d signal words checked, %0d mismatches",
             ledger.frames_noted, ledger.signals_checked, ledger.mismatches);
    $display("run: directed corners, four idle/stall mixes and a %0d-cycle result hold-off",
             HOLD_CYCLES);
    if (ledger.mismatches == 0 && ledger.pending_signals.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ can_signal_decoder_unit.f @@
+incdir+hw/rtl
hw/rtl/csd_pkg.sv
hw/rtl/csd_if.sv
hw/rtl/csd_datapath.sv
hw/rtl/csd_ctrl.sv
hw/rtl/can_signal_decoder_unit.sv
tb/sv/can_signal_decoder_unit_tb.sv
